>>> src/window_top_edge_visibility_defines.svh
// Assertion macros for the window top edge visibility block
`ifndef WINDOW_TOP_EDGE_VISIBILITY_DEFINES_SVH
`define WINDOW_TOP_EDGE_VISIBILITY_DEFINES_SVH

// same-cycle implication
`define WTEV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WTEV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/wtev_pkg.sv
// Shared types and constants for the window top edge visibility block
package wtev_pkg;

  localparam int MAX_WINDOWS_DEF = 32;
  localparam int MIN_W_BITS      = 15;

  typedef struct packed {
    logic        [15:0] id;
    logic        [15:0] depth;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic        [3:0]  kind;
  } win_rec_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
  } cover_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_SWEEP,
    ST_EMIT
  } state_t;

endpackage

>>> src/wtev_store.sv
// Window record memory, one write and one registered read port
module wtev_store import wtev_pkg::*; #(
  parameter int MAX_WINDOWS = MAX_WINDOWS_DEF,
  localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  win_rec_t      wdata,
  input  logic [IW-1:0] raddr,
  output win_rec_t      rdata
);

  win_rec_t mem [MAX_WINDOWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/wtev_cover_unit.sv
// Compare unit: row cover test and clip of one stored window
module wtev_cover_unit import wtev_pkg::*; (
  input  win_rec_t           rec,
  input  logic signed [15:0] win_left,
  input  logic signed [15:0] win_top,
  input  logic signed [15:0] win_right,
  output cover_t             cov
);

  logic signed [15:0] cl;
  logic signed [15:0] cr;
  logic               rows;

  always_comb begin
    rows    = (rec.top <= win_top) && (rec.bottom > win_top);
    cl      = (rec.left > win_left) ? rec.left : win_left;
    cr      = (rec.right < win_right) ? rec.right : win_right;
    cov.hit = rows && (cl < cr);
    cov.lo  = cl;
    cov.hi  = cr;
  end

endmodule

>>> src/wtev_ctrl.sv
// Sequencer: load, topmost selection, gap sweep passes and result issue
module wtev_ctrl import wtev_pkg::*; #(
  parameter int MAX_WINDOWS = MAX_WINDOWS_DEF,
  localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1,
  localparam int CW = $clog2(MAX_WINDOWS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  in_last,
  input  logic                  cfg_valid,
  input  logic [MIN_W_BITS-1:0] cfg_data,
  output logic                  busy,
  output logic                  we,
  output logic [IW-1:0]         waddr,
  output logic [IW-1:0]         raddr,
  input  win_rec_t              rdata,
  input  cover_t                cov,
  output win_rec_t              cur_win,
  output logic                  res_valid,
  output logic                  res_edge,
  output logic signed [15:0]    res_left,
  output logic signed [15:0]    res_right,
  output logic                  res_last,
  output logic                  res_ovf
);

  localparam logic [CW-1:0] CAP = CW'(MAX_WINDOWS);

  state_t                  state, state_next;
  logic [CW-1:0]           count, count_next;
  logic                    dropped, dropped_next;
  logic [MIN_W_BITS-1:0]   min_w;
  logic [CW-1:0]           rd_k, rd_k_next;
  logic                    rd_v, rd_v_next;
  logic [IW-1:0]           rd_kd;
  logic [MAX_WINDOWS-1:0]  done, done_next;
  logic [CW-1:0]           out_i, out_i_next;
  logic                    have, have_next;
  win_rec_t                best, best_next;
  logic [IW-1:0]           best_idx, best_idx_next;
  logic signed [15:0]      cur, cur_next;
  logic signed [15:0]      bl, bl_next;
  logic signed [15:0]      br, br_next;
  logic signed [15:0]      mlo, mlo_next;
  logic signed [15:0]      ext, ext_next;
  logic                    any, any_next;
  logic                    has_cov, has_cov_next;
  logic                    pass_end;
  logic                    is_last;
  logic signed [16:0]      best_w;
  logic signed [16:0]      tail_w;
  logic signed [16:0]      gap_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      dropped <= 1'b0;
      min_w   <= '0;
      rd_v    <= 1'b0;
      done    <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      rd_v    <= rd_v_next;
      done    <= done_next;
      if (cfg_valid) begin
        min_w <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_k     <= rd_k_next;
    rd_kd    <= rd_k[IW-1:0];
    out_i    <= out_i_next;
    have     <= have_next;
    best     <= best_next;
    best_idx <= best_idx_next;
    cur      <= cur_next;
    bl       <= bl_next;
    br       <= br_next;
    mlo      <= mlo_next;
    ext      <= ext_next;
    any      <= any_next;
    has_cov  <= has_cov_next;
  end

  always_comb begin
    pass_end = (rd_k == count) && !rd_v;
    is_last  = ((out_i + CW'(1)) == count);
    best_w   = 17'(br) - 17'(bl);
    tail_w   = 17'(best.right) - 17'(cur);
    gap_w    = 17'(mlo) - 17'(cur);
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    dropped_next  = dropped;
    rd_k_next     = rd_k;
    rd_v_next     = 1'b0;
    done_next     = done;
    out_i_next    = out_i;
    have_next     = have;
    best_next     = best;
    best_idx_next = best_idx;
    cur_next      = cur;
    bl_next       = bl;
    br_next       = br;
    mlo_next      = mlo;
    ext_next      = ext;
    any_next      = any;
    has_cov_next  = has_cov;
    we            = 1'b0;

    if ((state == ST_SEL) || (state == ST_SWEEP)) begin
      if (rd_k < count) begin
        rd_k_next = rd_k + CW'(1);
        rd_v_next = 1'b1;
      end
    end

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (count < CAP) begin
            we         = 1'b1;
            count_next = count + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (in_last) begin
            state_next = ST_SEL;
            rd_k_next  = '0;
            have_next  = 1'b0;
            done_next  = '0;
            out_i_next = '0;
          end
        end
      end
      ST_SEL: begin
        if (rd_v && !done[rd_kd] && (!have || (rdata.depth > best.depth))) begin
          best_next     = rdata;
          best_idx_next = rd_kd;
          have_next     = 1'b1;
        end
        if (pass_end) begin
          state_next   = ST_SWEEP;
          rd_k_next    = '0;
          cur_next     = best.left;
          bl_next      = best.left;
          br_next      = best.left;
          ext_next     = best.left;
          any_next     = 1'b0;
          has_cov_next = 1'b0;
        end
      end
      ST_SWEEP: begin
        if (rd_v && done[rd_kd] && cov.hit && (cov.hi > cur)) begin
          any_next = 1'b1;
          if (!any || (cov.lo < mlo)) begin
            mlo_next = cov.lo;
          end
          if ((cov.lo <= cur) && (cov.hi > ext)) begin
            ext_next = cov.hi;
          end
        end
        if (pass_end) begin
          rd_k_next = '0;
          any_next  = 1'b0;
          if (!any) begin
            state_next = ST_EMIT;
            if (!has_cov) begin
              bl_next = best.left;
              br_next = best.right;
            end else if (tail_w > best_w) begin
              bl_next = cur;
              br_next = best.right;
            end
          end else begin
            has_cov_next = 1'b1;
            if (mlo > cur) begin
              if (gap_w > best_w) begin
                bl_next = cur;
                br_next = mlo;
              end
              cur_next = mlo;
              ext_next = mlo;
            end else begin
              cur_next = ext;
            end
          end
        end
      end
      ST_EMIT: begin
        done_next[best_idx] = 1'b1;
        out_i_next          = out_i + CW'(1);
        have_next           = 1'b0;
        rd_k_next           = '0;
        if (is_last) begin
          state_next   = ST_IDLE;
          count_next   = '0;
          dropped_next = 1'b0;
        end else begin
          state_next = ST_SEL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign waddr     = count[IW-1:0];
  assign raddr     = rd_k[IW-1:0];
  assign cur_win   = best;
  assign res_valid = (state == ST_EMIT);
  assign res_edge  = (best_w >= $signed({2'b00, min_w}));
  assign res_left  = bl;
  assign res_right = br;
  assign res_last  = is_last;
  assign res_ovf   = is_last && dropped;

endmodule

>>> src/window_top_edge_visibility.sv
// Top level of the window top edge visibility block
//
//  channel   signals                          transaction
//  input     start / busy, window fields      start && !busy
//  config    cfg_valid / cfg_ready, cfg_data  cfg_valid && cfg_ready
//  result    result_valid, result fields      result_valid (one cycle)
//
// Loading accepts one window per cycle while idle. On the last window, for
// each stored window it picks the topmost remaining one in a pass over the
// record memory, then runs P sweep passes over it (P <= 2*covers+1) and
// issues one result; the single memory read port serves every pass.
// Reset is synchronous; the result side cannot stall, busy holds start off.
`include "window_top_edge_visibility_defines.svh"

module window_top_edge_visibility import wtev_pkg::*; #(
  parameter int MAX_WINDOWS = MAX_WINDOWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [15:0]           window_id,
  input  logic [15:0]           depth_z,
  input  logic signed [15:0]    rect_left,
  input  logic signed [15:0]    rect_top,
  input  logic signed [15:0]    rect_right,
  input  logic signed [15:0]    rect_bottom,
  input  logic [3:0]            window_kind,
  input  logic                  last_window,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [MIN_W_BITS-1:0] cfg_data,
  output logic                  result_valid,
  output logic                  has_edge,
  output logic [15:0]           owner_window,
  output logic signed [15:0]    edge_y,
  output logic signed [15:0]    edge_left,
  output logic signed [15:0]    edge_right,
  output logic [3:0]            edge_kind,
  output logic [15:0]           z_order,
  output logic                  last_result,
  output logic                  overflow
);

  localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

  win_rec_t      in_rec;
  win_rec_t      rdata;
  win_rec_t      cur_win;
  cover_t        cov;
  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;

  assign in_rec = '{id: window_id, depth: depth_z, left: rect_left, top: rect_top,
                    right: rect_right, bottom: rect_bottom, kind: window_kind};
  assign cfg_ready = 1'b1;

  wtev_store #(.MAX_WINDOWS(MAX_WINDOWS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_rec),
    .raddr (raddr),
    .rdata (rdata)
  );

  wtev_cover_unit u_cover (
    .rec       (rdata),
    .win_left  (cur_win.left),
    .win_top   (cur_win.top),
    .win_right (cur_win.right),
    .cov       (cov)
  );

  wtev_ctrl #(.MAX_WINDOWS(MAX_WINDOWS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .in_last   (last_window),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .we        (we),
    .waddr     (waddr),
    .raddr     (raddr),
    .rdata     (rdata),
    .cov       (cov),
    .cur_win   (cur_win),
    .res_valid (result_valid),
    .res_edge  (has_edge),
    .res_left  (edge_left),
    .res_right (edge_right),
    .res_last  (last_result),
    .res_ovf   (overflow)
  );

  assign owner_window = cur_win.id;
  assign edge_y       = cur_win.top;
  assign edge_kind    = cur_win.kind;
  assign z_order      = cur_win.depth;

  `WTEV_ASSERT_IMP(a_res_busy, result_valid, busy, "result while idle")
  `WTEV_ASSERT_IMP(a_ovf_last, result_valid && overflow, last_result, "overflow off last")
  `WTEV_ASSERT_NXT(a_last_idle, result_valid && last_result, !busy, "no idle after set")
  `WTEV_ASSERT_NXT(a_set_busy, start && !busy && last_window, busy, "set end not taken")

endmodule
